// ----- src/nested_state_interval_stack_macros.svh -----
// Assertion macros for the nested state interval stack.
`ifndef NESTED_STATE_INTERVAL_STACK_MACROS_SVH
`define NESTED_STATE_INTERVAL_STACK_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NSIS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nested state interval stack check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define NSIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nested state interval stack check failed");

`endif

// ----- src/nsis_pkg.sv -----
// Types and constants shared by the nested state interval stack modules.
package nsis_pkg;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   localparam logic CSR_DEPTH_LIMIT = 1'b0;
   localparam logic CSR_EMIT_ENABLE = 1'b1;

   localparam logic [6:0] DEPTH_LIMIT_RESET = 7'd64;

   typedef struct packed {
      logic        push;
      logic        pop;
      logic [31:0] state_id;
      logic [63:0] now_time;
   } stk_op_type;

   typedef struct packed {
      logic [31:0] top_state;
      logic [63:0] top_start;
      logic [31:0] below_state;
   } stk_view_type;

endpackage

// ----- src/nsis_stack.sv -----
// Stack storage: top entry in registers, lower state ids in a memory with a prefetched read.
module nsis_stack
   import nsis_pkg::*;
#(
   parameter int MAX_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  stk_op_type                     op,
   output logic [$clog2(MAX_DEPTH+1)-1:0] level,
   output stk_view_type                   view
);

   localparam int LW = $clog2(MAX_DEPTH + 1);
   localparam int AW = $clog2(MAX_DEPTH);

   logic [LW-1:0] level_ff, level_in;
   logic [31:0]   top_state_ff, top_state_in;
   logic [63:0]   top_start_ff, top_start_in;
   logic          byp_ff, byp_in;
   logic [31:0]   byp_state_ff;
   logic [31:0]   rd_state_ff;
   logic [31:0]   below_state;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [LW-1:0] wr_level;
   logic [LW-1:0] rd_level;

   logic [31:0] mem [MAX_DEPTH];

   assign below_state = byp_ff ? byp_state_ff : rd_state_ff;

   always_comb begin
      level_in     = level_ff;
      top_state_in = top_state_ff;
      top_start_in = top_start_ff;
      if (op.push) begin
         level_in     = level_ff + LW'(1);
         top_state_in = op.state_id;
         top_start_in = op.now_time;
      end else if (op.pop) begin
         level_in     = level_ff - LW'(1);
         top_state_in = below_state;
         top_start_in = op.now_time;
      end
      byp_in   = op.push;
      wr_en    = op.push && (level_ff != '0);
      wr_level = level_ff - LW'(1);
      wr_addr  = wr_level[AW-1:0];
      rd_level = (level_in >= LW'(2)) ? (level_in - LW'(2)) : '0;
      rd_addr  = rd_level[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         level_ff <= level_in;
         byp_ff   <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      top_state_ff <= top_state_in;
      top_start_ff <= top_start_in;
      byp_state_ff <= top_state_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= top_state_ff;
      end
      rd_state_ff <= mem[rd_addr];
   end

   assign level            = level_ff;
   assign view.top_state   = top_state_ff;
   assign view.top_start   = top_start_ff;
   assign view.below_state = below_state;

endmodule

// ----- src/nested_state_interval_stack.sv -----
// A result is registered and valid in the cycle after its item is accepted.
// One item per cycle unless a held result stalls the input, set by the top entry held in
// registers and the next-lower id prefetched through the registered memory read port.
// Reset clears the stack level and the result valid flag, sets the depth limit to 64 and
// enables emission; the stack memory is not cleared and needs no clearing pass.
`include "nested_state_interval_stack_macros.svh"

module nested_state_interval_stack
   import nsis_pkg::*;
#(
   parameter int MAX_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [31:0] req_state_id,
   input  logic [63:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_event_valid,
   output logic [31:0] rsp_event_state,
   output logic [63:0] rsp_event_start,
   output logic [63:0] rsp_event_end,
   output logic        rsp_stack_empty
);

   localparam int LW = $clog2(MAX_DEPTH + 1);
   localparam int CW = (LW > 7) ? LW : 7;

   logic [6:0]    depth_limit_ff;
   logic          emit_enable_ff;
   logic [LW-1:0] level;
   stk_op_type    op;
   stk_view_type  view;
   logic          accept;
   logic          is_push;
   logic          full;
   logic          push_ok;
   logic          pop_ok;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic          rsp_event_valid_ff, rsp_event_valid_in;
   logic [31:0]   rsp_event_state_ff, rsp_event_state_in;
   logic [63:0]   rsp_event_start_ff, rsp_event_start_in;
   logic [63:0]   rsp_event_end_ff, rsp_event_end_in;
   logic          rsp_stack_empty_ff, rsp_stack_empty_in;

   nsis_stack #(
      .MAX_DEPTH(MAX_DEPTH)
   ) u_stack (
      .clock(clock),
      .reset(reset),
      .op   (op),
      .level(level),
      .view (view)
   );

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_push   = (req_cmd == CMD_PUSH);

   always_comb begin
      full    = (CW'(level) >= CW'(depth_limit_ff)) || (level >= LW'(MAX_DEPTH));
      push_ok = is_push && !full;
      pop_ok  = !is_push && (level != '0);

      op.push     = accept && push_ok;
      op.pop      = accept && pop_ok;
      op.state_id = req_state_id;
      op.now_time = req_now_time;

      rsp_status_in = STATUS_OK;
      if (is_push && full) begin
         rsp_status_in = STATUS_OVERFLOW;
      end else if (!is_push && (level == '0)) begin
         rsp_status_in = STATUS_UNDERFLOW;
      end

      rsp_event_valid_in = emit_enable_ff && ((push_ok && (level != '0)) || pop_ok);
      rsp_event_state_in = rsp_event_valid_in ? view.top_state : '0;
      rsp_event_start_in = rsp_event_valid_in ? view.top_start : '0;
      rsp_event_end_in   = rsp_event_valid_in ? req_now_time : '0;
      rsp_stack_empty_in = ((level == '0) && !push_ok) || (pop_ok && (level == LW'(1)));

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_limit_ff <= DEPTH_LIMIT_RESET;
         emit_enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEPTH_LIMIT: begin
               depth_limit_ff <= csr_wdata;
            end
            CSR_EMIT_ENABLE: begin
               emit_enable_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff      <= rsp_status_in;
         rsp_event_valid_ff <= rsp_event_valid_in;
         rsp_event_state_ff <= rsp_event_state_in;
         rsp_event_start_ff <= rsp_event_start_in;
         rsp_event_end_ff   <= rsp_event_end_in;
         rsp_stack_empty_ff <= rsp_stack_empty_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_event_valid = rsp_event_valid_ff;
   assign rsp_event_state = rsp_event_state_ff;
   assign rsp_event_start = rsp_event_start_ff;
   assign rsp_event_end   = rsp_event_end_ff;
   assign rsp_stack_empty = rsp_stack_empty_ff;

   `NSIS_ASSERT_NOW(a_level_bound, clock, reset, 1'b1, level <= LW'(MAX_DEPTH))
   `NSIS_ASSERT_NEXT(a_push_grows, clock, reset, op.push, level == $past(level) + LW'(1))
   `NSIS_ASSERT_NOW(a_event_ok, clock, reset,
                    rsp_valid_ff && rsp_event_valid_ff, rsp_status_ff == STATUS_OK)
   `NSIS_ASSERT_NOW(a_underflow_empty, clock, reset,
                    rsp_valid_ff && (rsp_status_ff == STATUS_UNDERFLOW), rsp_stack_empty_ff)

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the nested state interval stack, with its own interval predictor.
module tb_top
   import nsis_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH = 64;

   typedef struct {
      cmd_type     cmd;
      logic [31:0] state_id;
      logic [63:0] now_time;
   } stack_cmd_type;

   typedef struct {
      status_type  status;
      logic        event_valid;
      logic [31:0] event_state;
      logic [63:0] event_start;
      logic [63:0] event_end;
      logic        stack_empty;
   } interval_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_DEPTH_LIMIT;
   logic [6:0]  csr_wdata = 7'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = CMD_PUSH;
   logic [31:0] req_state_id = 32'd0;
   logic [63:0] req_now_time = 64'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_event_valid;
   logic [31:0] rsp_event_state;
   logic [63:0] rsp_event_start;
   logic [63:0] rsp_event_end;
   logic        rsp_stack_empty;

   stack_cmd_type       command_q[$];
   interval_result_type interval_q[$];
   stack_cmd_type       cmd_in_flight;
   interval_result_type got_interval;

   // Predictor state and configuration.
   logic [31:0] trk_state[STACK_DEPTH];
   logic [63:0] trk_start[STACK_DEPTH];
   int unsigned trk_level;
   logic [6:0]  cfg_limit;
   logic        cfg_emit;

   int unsigned items_queued;
   int unsigned results_seen;
   int unsigned n_errors;
   int unsigned n_push, n_pop, n_overflow, n_underflow, n_events, n_peak;
   int unsigned send_gap, stall_left;
   bit          quiet;
   logic [63:0] tstamp;

   nested_state_interval_stack #(
      .MAX_DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_state_id    (req_state_id),
      .req_now_time    (req_now_time),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_event_valid (rsp_event_valid),
      .rsp_event_state (rsp_event_state),
      .rsp_event_start (rsp_event_start),
      .rsp_event_end   (rsp_event_end),
      .rsp_stack_empty (rsp_stack_empty)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic predict_interval(input stack_cmd_type c);
      interval_result_type r;
      int unsigned         lim;
      r.status      = STATUS_OK;
      r.event_valid = 1'b0;
      r.event_state = 32'd0;
      r.event_start = 64'd0;
      r.event_end   = 64'd0;
      lim = (cfg_limit > STACK_DEPTH) ? STACK_DEPTH : cfg_limit;
      if (c.cmd == CMD_PUSH) begin
         n_push++;
         if (trk_level >= lim) begin
            r.status = STATUS_OVERFLOW;
            n_overflow++;
         end else begin
            if (trk_level > 0 && cfg_emit) begin
               r.event_valid = 1'b1;
               r.event_state = trk_state[trk_level - 1];
               r.event_start = trk_start[trk_level - 1];
               r.event_end   = c.now_time;
            end
            trk_state[trk_level] = c.state_id;
            trk_start[trk_level] = c.now_time;
            trk_level++;
            if (trk_level > n_peak) n_peak = trk_level;
         end
      end else begin
         n_pop++;
         if (trk_level == 0) begin
            r.status = STATUS_UNDERFLOW;
            n_underflow++;
         end else begin
            if (cfg_emit) begin
               r.event_valid = 1'b1;
               r.event_state = trk_state[trk_level - 1];
               r.event_start = trk_start[trk_level - 1];
               r.event_end   = c.now_time;
            end
            trk_level--;
            if (trk_level > 0) trk_start[trk_level - 1] = c.now_time;
         end
      end
      r.stack_empty = (trk_level == 0);
      if (r.event_valid) n_events++;
      interval_q.push_back(r);
   endtask

   task automatic check_field(input string label, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         n_errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_interval(cmd_in_flight);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (command_q.size() > 0) begin
               cmd_in_flight = command_q.pop_front();
               req_valid     <= 1'b1;
               req_cmd       <= cmd_in_flight.cmd;
               req_state_id  <= cmd_in_flight.state_id;
               req_now_time  <= cmd_in_flight.now_time;
               if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (interval_q.size() == 0) begin
               n_errors++;
               $display("%0t: result with nothing expected, expected none, actual status %h",
                        $time, rsp_status);
            end else begin
               got_interval = interval_q.pop_front();
               check_field("status", 64'(got_interval.status), 64'(rsp_status));
               check_field("event_valid", 64'(got_interval.event_valid), 64'(rsp_event_valid));
               check_field("event_state", 64'(got_interval.event_state), 64'(rsp_event_state));
               check_field("event_start", got_interval.event_start, rsp_event_start);
               check_field("event_end", got_interval.event_end, rsp_event_end);
               check_field("stack_empty", 64'(got_interval.stack_empty), 64'(rsp_stack_empty));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
         end
      end
   end

   task automatic add_cmd(input cmd_type cmd, input logic [31:0] sid, input logic [63:0] t);
      stack_cmd_type c;
      c.cmd      = cmd;
      c.state_id = sid;
      c.now_time = t;
      command_q.push_back(c);
      items_queued++;
   endtask

   task automatic add_random(input int unsigned n, input int unsigned push_pct);
      logic [63:0] t;
      cmd_type     cmd;
      for (int unsigned k = 0; k < n; k++) begin
         cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
         case ($urandom_range(0, 9))
            0: t = 64'd0;
            1: t = '1;
            2, 3: t = {$urandom, $urandom};
            default: begin
               tstamp += $urandom_range(0, 5000);
               t = tstamp;
            end
         endcase
         add_cmd(cmd, $urandom, t);
      end
   endtask

   task automatic add_mixed(input int unsigned n);
      int unsigned chunk;
      int unsigned pct[4] = '{15, 50, 70, 90};
      while (n > 0) begin
         chunk = $urandom_range(8, 24);
         if (chunk > n) chunk = n;
         add_random(chunk, pct[$urandom_range(0, 3)]);
         n -= chunk;
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (results_seen != items_queued);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [6:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock);
      while (!csr_ready);
      if (idx == CSR_DEPTH_LIMIT) cfg_limit = val;
      else cfg_emit = val[0];
      csr_valid <= 1'b0;
   endtask

   initial begin
      trk_level = 0;
      cfg_limit = DEPTH_LIMIT_RESET;
      cfg_emit  = 1'b1;
      tstamp    = 64'd1000;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_cmd(CMD_POP, '1, '1);
      add_cmd(CMD_PUSH, 32'd0, 64'd0);
      add_cmd(CMD_PUSH, '1, '1);
      add_cmd(CMD_PUSH, $urandom, 64'd12345);
      add_cmd(CMD_POP, $urandom, 64'd23456);
      add_cmd(CMD_POP, $urandom, 64'd34567);
      add_cmd(CMD_PUSH, $urandom, 64'd40000);
      add_cmd(CMD_POP, 32'd0, 64'd45678);
      add_cmd(CMD_POP, 32'd0, 64'd50000);
      wait_idle();
      write_reg(CSR_DEPTH_LIMIT, 7'd1);
      add_cmd(CMD_PUSH, 32'hA5A5_5A5A, 64'd60000);
      add_cmd(CMD_PUSH, 32'h5A5A_A5A5, 64'd61000);
      add_cmd(CMD_POP, 32'd0, 64'd62000);
      wait_idle();
      write_reg(CSR_DEPTH_LIMIT, 7'd0);
      add_cmd(CMD_PUSH, $urandom, 64'd63000);
      add_cmd(CMD_POP, $urandom, 64'd64000);
      wait_idle();
      write_reg(CSR_DEPTH_LIMIT, 7'd64);
      write_reg(CSR_EMIT_ENABLE, 7'b1111110);
      add_cmd(CMD_PUSH, $urandom, 64'd65000);
      add_cmd(CMD_PUSH, $urandom, 64'd66000);
      add_cmd(CMD_POP, $urandom, 64'd67000);
      add_cmd(CMD_POP, $urandom, 64'd68000);
      wait_idle();
      write_reg(CSR_EMIT_ENABLE, 7'd1);
      add_cmd(CMD_PUSH, $urandom, 64'd70000);
      add_cmd(CMD_PUSH, $urandom, 64'd71000);
      add_cmd(CMD_PUSH, $urandom, 64'd72000);
      wait_idle();
      write_reg(CSR_DEPTH_LIMIT, 7'd1);
      add_cmd(CMD_PUSH, $urandom, 64'd73000);
      add_cmd(CMD_POP, $urandom, 64'd74000);
      add_cmd(CMD_POP, $urandom, 64'd75000);
      add_cmd(CMD_POP, $urandom, 64'd76000);
      wait_idle();

      write_reg(CSR_DEPTH_LIMIT, 7'd64);
      add_random(70, 95);
      wait_idle();
      add_random(75, 10);
      wait_idle();
      write_reg(CSR_DEPTH_LIMIT, 7'd2);
      add_mixed(80);
      wait_idle();
      write_reg(CSR_DEPTH_LIMIT, 7'd127);
      add_random(75, 90);
      add_random(30, 40);
      wait_idle();
      write_reg(CSR_DEPTH_LIMIT, 7'd1);
      write_reg(CSR_EMIT_ENABLE, {6'($urandom), 1'b0});
      add_mixed(80);
      wait_idle();
      write_reg(CSR_DEPTH_LIMIT, 7'($urandom_range(3, 10)));
      write_reg(CSR_EMIT_ENABLE, {6'($urandom), 1'b1});
      add_mixed(80);
      wait_idle();
      write_reg(CSR_DEPTH_LIMIT, 7'd0);
      add_mixed(40);
      wait_idle();
      write_reg(CSR_DEPTH_LIMIT, 7'd64);
      write_reg(CSR_EMIT_ENABLE, 7'd0);
      add_mixed(80);
      wait_idle();
      quiet = 1'b1;
      write_reg(CSR_DEPTH_LIMIT, 7'($urandom_range(4, 16)));
      write_reg(CSR_EMIT_ENABLE, 7'd1);
      add_mixed(80);
      wait_idle();
      repeat (5) @(posedge clock);

      if (interval_q.size() != 0) begin
         n_errors++;
         $display("%0t: results outstanding at the end, expected 0, actual %0d",
                  $time, interval_q.size());
      end
      $display("Ran %0d pushes and %0d pops, with %0d overflows and %0d underflows.",
               n_push, n_pop, n_overflow, n_underflow);
      $display("Saw %0d interval events; the deepest stack held %0d entries.",
               n_events, n_peak);
      if (n_errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_top: errors");
      $finish;
   end

endmodule
